/* rtl/core/kabf_pkg.sv */
// Shared types, constants and a saturation function for the angle and bias Kalman filter.
package kabf_pkg;

  localparam logic [2:0] RegQAngle = 3'd0;
  localparam logic [2:0] RegQBias = 3'd1;
  localparam logic [2:0] RegRMeasure = 3'd2;
  localparam logic [2:0] RegStartAngle = 3'd3;
  localparam logic [2:0] RegStartBias = 3'd4;

  localparam logic [30:0] QAngleRst = 31'd16777;
  localparam logic [30:0] QBiasRst = 31'd50332;
  localparam logic [30:0] RMeasureRst = 31'd503316;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RATE,
    ST_ANG_MUL,
    ST_ANG_ADD,
    ST_T,
    ST_P11_ADD,
    ST_T_HI,
    ST_P00_ADD,
    ST_Y,
    ST_DIV0,
    ST_DIV1,
    ST_K0Y,
    ST_K1Y,
    ST_K0P00,
    ST_K0P01,
    ST_K1P00,
    ST_K1P01,
    ST_OUT
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

/* rtl/core/kabf_div.sv */
// Radix-2 restoring divider: gain = sat32((p << 24) / s), s > 0, truncation to zero.
module kabf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] p_i,
  input  logic        [32:0] s_i,
  output logic               busy_o,
  output logic signed [31:0] q_o
);
  logic [55:0] dvd_q, dvd_d;
  logic [32:0] s_q, s_d;
  logic [33:0] rem_q, rem_d;
  logic [55:0] quo_q, quo_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d, busy_q, busy_d;
  logic [33:0] trial;
  logic [33:0] diff;
  logic signed [57:0] sq;

  always_comb begin
    dvd_d = dvd_q; s_d = s_q; rem_d = rem_q; quo_d = quo_q;
    cnt_d = cnt_q; neg_d = neg_q; busy_d = busy_q;
    trial = {rem_q[32:0], dvd_q[55]};
    diff = trial - {1'b0, s_q};
    if (start_i) begin
      dvd_d = {(p_i[31] ? 32'(-p_i) : 32'(p_i)), 24'd0};
      s_d = s_i; rem_d = '0; quo_d = '0; cnt_d = 6'd56;
      neg_d = p_i[31]; busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[54:0], 1'b0};
      if (!diff[33]) begin
        rem_d = diff; quo_d = {quo_q[54:0], 1'b1};
      end else begin
        rem_d = trial; quo_d = {quo_q[54:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d; s_q <= s_d; rem_q <= rem_d; quo_q <= quo_d; neg_q <= neg_d;
  end

  // magnitude quotient, sign restored, then clamped to 32 bits
  assign sq = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
  assign q_o = kabf_pkg::sat32(66'(sq));
  assign busy_o = busy_q;
endmodule

/* rtl/core/kalman_angle_bias_filter.sv */
// Top level of the two-state angle and gyro-bias Kalman filter.
//  channel | dir | signals
//  in      | in  | in_valid_i, in_ready_o, mode_i, measured_angle_i, gyro_rate_i, time_step_i
//  out     | out | out_valid_o, out_ready_i, angle_estimate_o, rate_estimate_o
//  cfg     | in  | cfg_we_i, cfg_idx_i, cfg_wdata_i
// An update word runs through 15 sequencer steps that share one 33x33 multiplier,
// plus two gain divisions (56 quotient bits, one per cycle, then capture); when
// S <= 0 the divisions are not started and both gains are zero.
// A restart word gives its result in the cycle after acceptance.
// Reset clears state and covariance and returns registers to their defaults.
// A new word is taken in idle once the result register is empty or being read.
module kalman_angle_bias_filter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic signed [31:0] measured_angle_i,
  input  logic signed [31:0] gyro_rate_i,
  input  logic        [15:0] time_step_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] angle_estimate_o,
  output logic signed [31:0] rate_estimate_o,
  input  logic               cfg_we_i,
  input  logic        [2:0]  cfg_idx_i,
  input  logic        [31:0] cfg_wdata_i
);
  kabf_pkg::state_e st_q, st_d;
  logic [30:0] qa_q, qb_q, rm_q;
  logic signed [31:0] sa_q, sb_q;
  logic signed [31:0] ang_q, bias_q, rate_q, p00_q, p01_q, p10_q, p11_q;
  logic signed [31:0] np00_q, np01_q, np10_q, np11_q;
  logic signed [31:0] meas_q, gyro_q, y_q, k0_q, k1_q;
  logic [15:0] dt_q;
  logic signed [65:0] acc_q;
  logic signed [65:0] prod_q;
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic div_start, div_busy;
  logic signed [31:0] dq;
  logic signed [31:0] dp;
  logic signed [32:0] s_w;
  logic s_pos;
  logic out_v_q, out_v_d;
  logic signed [31:0] oa_q, or_q;
  logic upd;

  // Shared multiplier operands; product registered.
  always_comb begin
    ma = '0; mb = '0;
    unique case (st_q)
      kabf_pkg::ST_ANG_MUL: begin ma = 33'(rate_q); mb = {17'd0, dt_q}; end
      kabf_pkg::ST_ANG_ADD: begin ma = 33'(p11_q); mb = {17'd0, dt_q}; end
      kabf_pkg::ST_T:       begin ma = {2'b0, qb_q}; mb = {17'd0, dt_q}; end
      // dt*t in two halves: t is up to 34 bits wide
      kabf_pkg::ST_P11_ADD: begin ma = acc_q[49:17]; mb = {17'd0, dt_q}; end
      kabf_pkg::ST_T_HI:    begin ma = {16'd0, acc_q[16:0]}; mb = {17'd0, dt_q}; end
      kabf_pkg::ST_K0Y:     begin ma = 33'(k0_q); mb = 33'(y_q); end
      kabf_pkg::ST_K1Y:     begin ma = 33'(k1_q); mb = 33'(y_q); end
      kabf_pkg::ST_K0P00:   begin ma = 33'(k0_q); mb = 33'(np00_q); end
      kabf_pkg::ST_K0P01:   begin ma = 33'(k0_q); mb = 33'(np01_q); end
      kabf_pkg::ST_K1P00:   begin ma = 33'(k1_q); mb = 33'(np00_q); end
      kabf_pkg::ST_K1P01:   begin ma = 33'(k1_q); mb = 33'(np01_q); end
      default: ;
    endcase
    prod = 66'(ma) * 66'(mb);
  end

  assign s_w = 33'(np00_q) + $signed({2'b0, rm_q});
  assign s_pos = !s_w[32] && (s_w != '0);
  assign dp = (st_q == kabf_pkg::ST_DIV0) ? np10_q : np00_q;
  assign upd = in_valid_i && in_ready_o;
  assign in_ready_o = (st_q == kabf_pkg::ST_IDLE) && (!out_v_q || out_ready_i);

  kabf_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .p_i(dp), .s_i(s_w),
    .busy_o(div_busy), .q_o(dq)
  );

  always_comb begin
    st_d = st_q;
    div_start = 1'b0;
    unique case (st_q)
      kabf_pkg::ST_IDLE:    if (upd && !mode_i) st_d = kabf_pkg::ST_RATE;
      kabf_pkg::ST_RATE:    st_d = kabf_pkg::ST_ANG_MUL;
      kabf_pkg::ST_ANG_MUL: st_d = kabf_pkg::ST_ANG_ADD;
      kabf_pkg::ST_ANG_ADD: st_d = kabf_pkg::ST_T;
      kabf_pkg::ST_T:       st_d = kabf_pkg::ST_P11_ADD;
      kabf_pkg::ST_P11_ADD: st_d = kabf_pkg::ST_T_HI;
      kabf_pkg::ST_T_HI:    st_d = kabf_pkg::ST_P00_ADD;
      kabf_pkg::ST_P00_ADD: st_d = kabf_pkg::ST_Y;
      kabf_pkg::ST_Y: begin
        st_d = kabf_pkg::ST_DIV0; div_start = s_pos;
      end
      kabf_pkg::ST_DIV0: if (!div_busy) begin
        st_d = kabf_pkg::ST_DIV1; div_start = s_pos;
      end
      kabf_pkg::ST_DIV1:    if (!div_busy) st_d = kabf_pkg::ST_K0Y;
      kabf_pkg::ST_K0Y:     st_d = kabf_pkg::ST_K1Y;
      kabf_pkg::ST_K1Y:     st_d = kabf_pkg::ST_K0P00;
      kabf_pkg::ST_K0P00:   st_d = kabf_pkg::ST_K0P01;
      kabf_pkg::ST_K0P01:   st_d = kabf_pkg::ST_K1P00;
      kabf_pkg::ST_K1P00:   st_d = kabf_pkg::ST_K1P01;
      kabf_pkg::ST_K1P01:   st_d = kabf_pkg::ST_OUT;
      kabf_pkg::ST_OUT:     st_d = kabf_pkg::ST_IDLE;
      default:              st_d = kabf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_v_d = out_v_q;
    if (out_v_q && out_ready_i) out_v_d = 1'b0;
    if ((upd && mode_i) || (st_q == kabf_pkg::ST_OUT)) out_v_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= kabf_pkg::ST_IDLE;
      qa_q <= kabf_pkg::QAngleRst; qb_q <= kabf_pkg::QBiasRst;
      rm_q <= kabf_pkg::RMeasureRst; sa_q <= '0; sb_q <= '0;
      ang_q <= '0; bias_q <= '0; rate_q <= '0;
      p00_q <= '0; p01_q <= '0; p10_q <= '0; p11_q <= '0;
      oa_q <= '0; or_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      out_v_q <= out_v_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          kabf_pkg::RegQAngle:     qa_q <= cfg_wdata_i[30:0];
          kabf_pkg::RegQBias:      qb_q <= cfg_wdata_i[30:0];
          kabf_pkg::RegRMeasure:   rm_q <= cfg_wdata_i[30:0];
          kabf_pkg::RegStartAngle: sa_q <= cfg_wdata_i;
          kabf_pkg::RegStartBias:  sb_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      unique case (st_q)
        kabf_pkg::ST_IDLE:
          if (upd && mode_i) begin
            ang_q <= sa_q; bias_q <= sb_q;
            p00_q <= '0; p01_q <= '0; p10_q <= '0; p11_q <= '0;
            oa_q <= sa_q; or_q <= rate_q;
          end
        kabf_pkg::ST_RATE:
          rate_q <= kabf_pkg::sat32(66'(gyro_q) - 66'(bias_q));
        kabf_pkg::ST_ANG_ADD:
          ang_q <= kabf_pkg::sat32(66'(ang_q) + (prod_q >>> 16));
        kabf_pkg::ST_K1Y: ang_q <= kabf_pkg::sat32(66'(ang_q) + (prod_q >>> 24));
        kabf_pkg::ST_K0P00: bias_q <= kabf_pkg::sat32(66'(bias_q) + (prod_q >>> 24));
        kabf_pkg::ST_K0P01: p00_q <= kabf_pkg::sat32(66'(np00_q) - (prod_q >>> 24));
        kabf_pkg::ST_K1P00: p01_q <= kabf_pkg::sat32(66'(np01_q) - (prod_q >>> 24));
        kabf_pkg::ST_K1P01: p10_q <= kabf_pkg::sat32(66'(np10_q) - (prod_q >>> 24));
        kabf_pkg::ST_OUT: begin
          p11_q <= kabf_pkg::sat32(66'(np11_q) - (prod_q >>> 24));
          oa_q <= ang_q; or_q <= rate_q;
        end
        default: ;
      endcase
    end
  end

  // Product register, predicted covariance, innovation, gain and operand capture.
  always_ff @(posedge clk_i) begin
    prod_q <= prod;
    if (upd) begin
      meas_q <= measured_angle_i; gyro_q <= gyro_rate_i; dt_q <= time_step_i;
    end
    unique case (st_q)
      kabf_pkg::ST_T: begin
        np01_q <= kabf_pkg::sat32(66'(p01_q) - (prod_q >>> 16));
        np10_q <= kabf_pkg::sat32(66'(p10_q) - (prod_q >>> 16));
        acc_q <= (prod_q >>> 16) - 66'(p01_q) - 66'(p10_q) + $signed({35'd0, qa_q});
      end
      kabf_pkg::ST_P11_ADD:
        np11_q <= kabf_pkg::sat32(66'(p11_q) + (prod_q >>> 16));
      kabf_pkg::ST_T_HI: acc_q <= prod_q <<< 17;
      kabf_pkg::ST_P00_ADD:
        np00_q <= kabf_pkg::sat32(66'(p00_q) + ((acc_q + prod_q) >>> 16));
      kabf_pkg::ST_Y: y_q <= kabf_pkg::sat32(66'(meas_q) - 66'(ang_q));
      kabf_pkg::ST_DIV0: if (!div_busy) k0_q <= s_pos ? dq : '0;
      kabf_pkg::ST_DIV1: if (!div_busy) k1_q <= s_pos ? dq : '0;
      default: ;
    endcase
  end

  assign out_valid_o = out_v_q;
  assign angle_estimate_o = oa_q;
  assign rate_estimate_o = or_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> st_q == kabf_pkg::ST_IDLE) else $error("ready outside idle");
  a_one_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == kabf_pkg::ST_OUT) |=> out_v_q) else $error("result lost");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(angle_estimate_o)
    && $stable(rate_estimate_o)) else $error("result word changed while waiting");
endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the angle and gyro-bias Kalman filter.
module tb_top;

  localparam logic ModeUpdate  = 1'b0;
  localparam logic ModeRestart = 1'b1;
  localparam int   IdleLimit   = 20000;
  localparam int   NumPhases   = 6;
  localparam int   PhaseWords  = 240;

  typedef struct {
    logic              mode;
    logic signed [31:0] meas;
    logic signed [31:0] gyro;
    logic [15:0]       dt;
    bit                typed;
    logic signed [31:0] ang_exp;
    logic signed [31:0] rate_exp;
  } stim_row_t;

  typedef struct {
    logic signed [31:0] ang;
    logic signed [31:0] rate;
  } estimate_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic mode_i = 1'b0;
  logic signed [31:0] measured_angle_i = '0;
  logic signed [31:0] gyro_rate_i = '0;
  logic [15:0] time_step_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] angle_estimate_o;
  logic signed [31:0] rate_estimate_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;

  kalman_angle_bias_filter dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // filter model state
  logic [30:0] m_q_angle, m_q_bias, m_r_meas;
  logic signed [31:0] m_start_angle, m_start_bias;
  logic signed [31:0] m_angle, m_bias, m_rate;
  logic signed [31:0] m_cov[4];

  estimate_t pending_estimates[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint kgain(longint p, longint s);
    if (s <= 0) return 0;
    return clamp32((p * 64'sd16777216) / s);
  endfunction

  function automatic estimate_t filter_step(logic mode, logic signed [31:0] meas,
                                            logic signed [31:0] gyro, logic [15:0] dt_in);
    longint dt, p00, p01, p10, p11, dtp11, t, y, s, k0, k1;
    estimate_t e;
    if (mode == ModeRestart) begin
      m_angle = m_start_angle;
      m_bias  = m_start_bias;
      foreach (m_cov[i]) m_cov[i] = '0;
    end else begin
      dt  = longint'(dt_in);
      p00 = m_cov[0]; p01 = m_cov[1]; p10 = m_cov[2]; p11 = m_cov[3];
      m_rate  = 32'(clamp32(longint'(gyro) - longint'(m_bias)));
      m_angle = 32'(clamp32(longint'(m_angle) + ((dt * longint'(m_rate)) >>> 16)));
      dtp11 = (dt * p11) >>> 16;
      t   = dtp11 - p01 - p10 + longint'(m_q_angle);
      p00 = clamp32(p00 + ((dt * t) >>> 16));
      p01 = clamp32(p01 - dtp11);
      p10 = clamp32(p10 - dtp11);
      p11 = clamp32(p11 + ((longint'(m_q_bias) * dt) >>> 16));
      y  = clamp32(longint'(meas) - longint'(m_angle));
      s  = p00 + longint'(m_r_meas);
      k0 = kgain(p00, s);
      k1 = kgain(p10, s);
      m_angle = 32'(clamp32(longint'(m_angle) + ((k0 * y) >>> 24)));
      m_bias  = 32'(clamp32(longint'(m_bias) + ((k1 * y) >>> 24)));
      m_cov[0] = 32'(clamp32(p00 - ((k0 * p00) >>> 24)));
      m_cov[1] = 32'(clamp32(p01 - ((k0 * p01) >>> 24)));
      m_cov[2] = 32'(clamp32(p10 - ((k1 * p00) >>> 24)));
      m_cov[3] = 32'(clamp32(p11 - ((k1 * p01) >>> 24)));
    end
    e.ang  = m_angle;
    e.rate = m_rate;
    return e;
  endfunction

  // leaves cfg_we_i high; caller lowers it after the batch
  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      kabf_pkg::RegQAngle:     m_q_angle = data[30:0];
      kabf_pkg::RegQBias:      m_q_bias = data[30:0];
      kabf_pkg::RegRMeasure:   m_r_meas = data[30:0];
      kabf_pkg::RegStartAngle: m_start_angle = data;
      kabf_pkg::RegStartBias:  m_start_bias = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_word(stim_row_t r);
    estimate_t e;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 150)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i       <= 1'b1;
    mode_i           <= r.mode;
    measured_angle_i <= r.meas;
    gyro_rate_i      <= r.gyro;
    time_step_i      <= r.dt;
    do @(posedge clk_i); while (!in_ready_o);
    e = filter_step(r.mode, r.meas, r.gyro, r.dt);
    if (r.typed) begin
      e.ang  = r.ang_exp;
      e.rate = r.rate_exp;
    end
    pending_estimates.push_back(e);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_estimates.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic stim_row_t rand_word();
    stim_row_t r;
    r.typed = 1'b0;
    r.mode = ($urandom_range(0, 99) < 4) ? ModeRestart : ModeUpdate;
    if ($urandom_range(0, 9) == 0) begin
      r.meas = $urandom;
      r.gyro = $urandom;
      r.dt   = 16'($urandom);
    end else begin
      // realistic IMU words: +-90 deg, +-250 dps, dt from 0 to 700 in units of 2^-16 s
      r.meas = $signed($urandom_range(0, 11796480)) - 32'sd5898240;
      r.gyro = $signed($urandom_range(0, 32768000)) - 32'sd16384000;
      r.dt   = 16'($urandom_range(0, 700));
    end
    return r;
  endfunction

  // receiver stall pattern steps through four modes, chosen by bits 9:8 of the cycle counter
  int rx_cycle = 0;
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    case (rx_cycle[9:8])
      2'd0: out_ready_i <= 1'b1;
      2'd1: out_ready_i <= 1'($urandom_range(0, 1));
      2'd2: out_ready_i <= ($urandom_range(0, 7) == 0);
      default: out_ready_i <= (rx_cycle[4:0] > 5'd20);
    endcase
  end

  always @(posedge clk_i) begin
    estimate_t e;
    if (out_valid_o && out_ready_i) begin
      if (pending_estimates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: angle %h rate %h",
                                       angle_estimate_o, rate_estimate_o);
      end else begin
        e = pending_estimates.pop_front();
        if (angle_estimate_o !== e.ang || rate_estimate_o !== e.rate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: angle exp %h got %h, rate exp %h got %h",
                     e.ang, angle_estimate_o, e.rate, rate_estimate_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  stim_row_t directed[$];

  initial begin
    stim_row_t r;
    m_q_angle = kabf_pkg::QAngleRst; m_q_bias = kabf_pkg::QBiasRst;
    m_r_meas = kabf_pkg::RMeasureRst;
    m_start_angle = '0; m_start_bias = '0;
    m_angle = '0; m_bias = '0; m_rate = '0;
    foreach (m_cov[i]) m_cov[i] = '0;

    //                mode         meas           gyro           dt      typed ang   rate
    directed = '{
      '{ModeRestart, 32'sh7fffffff, 32'sh7fffffff, 16'hffff, 1, 32'sh0, 32'sh0},
      '{ModeUpdate,  32'sh0,        32'sh7fffffff, 16'h0,    1, 32'sh0, 32'sh7fffffff},
      '{ModeUpdate,  32'sh0,        32'sh80000000, 16'h0,    1, 32'sh0, 32'sh80000000},
      '{ModeUpdate,  32'sh7fffffff, 32'sh0,        16'hffff, 0, 0, 0},
      '{ModeUpdate,  32'sh80000000, 32'sh7fffffff, 16'hffff, 0, 0, 0},
      '{ModeUpdate,  32'sh80000000, 32'sh80000000, 16'hffff, 0, 0, 0},
      '{ModeUpdate,  32'sh7fffffff, 32'sh80000000, 16'h0001, 0, 0, 0},
      '{ModeUpdate,  32'sh00010000, 32'sh00000000, 16'h0041, 0, 0, 0},
      '{ModeUpdate,  32'sh00020000, 32'sh00008000, 16'h0041, 0, 0, 0},
      '{ModeRestart, 32'sh0,        32'sh0,        16'h0,    0, 0, 0},
      '{ModeUpdate,  32'shffff0000, 32'sh00100000, 16'h8000, 0, 0, 0},
      '{ModeUpdate,  32'sh0,        32'shffffffff, 16'hffff, 0, 0, 0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_word(directed[i]);
    drain();

    // zero measurement noise with cleared covariance gives zero innovation variance
    cfg_write(kabf_pkg::RegRMeasure, 32'h0);
    cfg_write(kabf_pkg::RegStartAngle, 32'h7fffffff);
    cfg_write(kabf_pkg::RegStartBias, 32'h80000000);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    r = '{ModeRestart, 32'sh0, 32'sh0, 16'h0, 1, 32'sh7fffffff, m_rate};
    send_word(r);
    r = '{ModeUpdate, 32'sh0, 32'sh0, 16'h0, 0, 0, 0};
    send_word(r);
    r = '{ModeUpdate, 32'sh12345678, 32'sh7fffffff, 16'hffff, 0, 0, 0};
    send_word(r);
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin
          cfg_write(kabf_pkg::RegQAngle, 32'hffffffff);  // bit 31 is masked off
          cfg_write(kabf_pkg::RegQBias, 32'h7fffffff);
          cfg_write(kabf_pkg::RegRMeasure, 32'h7fffffff);
          cfg_write(3'd5, $urandom);
          cfg_write(kabf_pkg::RegStartAngle, 32'h80000000);
          cfg_write(kabf_pkg::RegStartBias, 32'h7fffffff);
        end
        1: begin
          cfg_write(kabf_pkg::RegQAngle, 32'h0);
          cfg_write(kabf_pkg::RegQBias, 32'h0);
          cfg_write(kabf_pkg::RegRMeasure, 32'h1);
          cfg_write(3'd7, $urandom);
        end
        2: begin
          cfg_write(kabf_pkg::RegQAngle, 32'd16777);
          cfg_write(kabf_pkg::RegQBias, 32'd50332);
          cfg_write(kabf_pkg::RegRMeasure, 32'd503316);
          cfg_write(kabf_pkg::RegStartAngle, 32'h0);
          cfg_write(kabf_pkg::RegStartBias, 32'h0);
        end
        default: begin
          cfg_write(kabf_pkg::RegQAngle, $urandom_range(0, 1 << 22));
          cfg_write(kabf_pkg::RegQBias, $urandom_range(0, 1 << 22));
          cfg_write(kabf_pkg::RegRMeasure, $urandom_range(0, 1 << 25));
          cfg_write(kabf_pkg::RegStartAngle, $urandom);
          cfg_write(kabf_pkg::RegStartBias, $urandom_range(0, 1 << 18));
          cfg_write(3'd6, $urandom);
        end
      endcase
      cfg_we_i <= 1'b0;
      @(posedge clk_i);
      for (int n = 0; n < PhaseWords; n++) send_word(rand_word());
      drain();
    end

    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && pending_estimates.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
